// ===== rtl/core/parse_unsigned_integer_text_unit_macros.svh =====
// assertion macros shared by the text-to-integer parser modules
`ifndef PARSE_UNSIGNED_INTEGER_TEXT_UNIT_MACROS_SVH
`define PARSE_UNSIGNED_INTEGER_TEXT_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PUI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// next-cycle implication, checked outside reset
`define PUI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

// ===== rtl/core/puit_pkg.sv =====
// shared types and constants of the text-to-integer parser
package puit_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int VALUE_BITS  = 64;
    localparam int BASE_BITS   = 6;
    localparam int CHAR_BITS   = 8;
    localparam int STATUS_BITS = 2;

    localparam int RES_BITS    = VALUE_BITS + OFFSET_BITS + STATUS_BITS;
    localparam int TDATA_W     = ((RES_BITS + 7) / 8) * 8;

    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
    localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(36);
    localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
    localparam logic [BASE_BITS-1:0] BASE_BAD   = BASE_BITS'(1);
    localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
    localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
    localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK      = 2'd0,
        ST_NODIG   = 2'd1,
        ST_OVER    = 2'd2,
        ST_BADBASE = 2'd3
    } t_status;

    // one classified character travelling from front to back
    typedef struct packed {
        logic                 start;
        logic                 bad_base;
        logic [BASE_BITS-1:0] base;
        logic                 dig_ok;
        logic [BASE_BITS-1:0] dig;
        logic                 is_space;
        logic                 is_sign;
        logic                 is_minus;
        logic                 is_zero;
        logic                 is_x;
    } t_item;

    typedef struct packed {
        t_status                status;
        logic [OFFSET_BITS-1:0] end_offset;
        logic [VALUE_BITS-1:0]  value;
    } t_result;

endpackage

// ===== rtl/core/puit_front.sv =====
// front end: base register and per-character classification
module puit_front
    import puit_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [BASE_BITS-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CHAR_BITS-1:0] i_char,
    input  logic                 i_start,
    input  logic                 i_q_ready,
    output logic                 o_push,
    output t_item                o_item
);

    logic [BASE_BITS-1:0] r_base;
    logic [CHAR_BITS-1:0] w_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_q_ready;
    assign o_push      = i_valid && i_q_ready;

    always_comb begin
        o_item          = '0;
        w_rel           = '0;
        o_item.start    = i_start;
        o_item.base     = r_base;
        o_item.bad_base = (r_base == BASE_BAD) || (r_base > BASE_MAX);
        o_item.is_space = (i_char == 8'd32) || ((i_char >= 8'd9) && (i_char <= 8'd13));
        o_item.is_sign  = (i_char == 8'h2b) || (i_char == 8'h2d);
        o_item.is_minus = (i_char == 8'h2d);
        o_item.is_zero  = (i_char == 8'h30);
        o_item.is_x     = (i_char == 8'h78) || (i_char == 8'h58);
        // digits 0-9 then letters of either case as 10..35
        if ((i_char >= 8'h30) && (i_char <= 8'h39)) begin
            w_rel         = i_char - 8'h30;
            o_item.dig_ok = 1'b1;
        end else if ((i_char >= 8'h61) && (i_char <= 8'h7a)) begin
            w_rel         = i_char - 8'h61 + 8'd10;
            o_item.dig_ok = 1'b1;
        end else if ((i_char >= 8'h41) && (i_char <= 8'h5a)) begin
            w_rel         = i_char - 8'h41 + 8'd10;
            o_item.dig_ok = 1'b1;
        end
        o_item.dig = w_rel[BASE_BITS-1:0];
    end

endmodule

// ===== rtl/core/puit_queue.sv =====
// short queue of classified characters between front and back
module puit_queue
    import puit_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

`include "parse_unsigned_integer_text_unit_macros.svh"

    `PUI_ASSERT_NOW(a_no_push_full, i_push, r_count != QCNT_W'(QDEPTH))
    `PUI_ASSERT_NOW(a_no_pop_empty, i_pop, r_count != '0)

endmodule

// ===== rtl/core/puit_back.sv =====
// back end: parse state machine, 64-bit accumulate and result register
module puit_back
    import puit_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam int                     PROD_W  = VALUE_BITS + BASE_BITS;

    t_phase                 r_phase, n_phase;
    logic [VALUE_BITS-1:0]  r_acc, n_acc;
    logic                   r_neg, n_neg;
    logic [BASE_BITS-1:0]   r_eb, n_eb;
    logic                   r_ovf, n_ovf;
    logic                   r_seen, n_seen;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_out_valid;
    t_result                r_out, n_out;
    logic                   w_emit;
    logic                   w_adv;
    logic                   w_prefix;
    logic                   w_digit;
    logic [PROD_W-1:0]      w_prod;

    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_eb     = r_eb;
        n_ovf    = r_ovf;
        n_seen   = r_seen;
        n_pos    = r_pos;
        n_out    = r_out;
        w_emit   = 1'b0;
        w_adv    = 1'b0;
        w_prefix = 1'b0;
        w_digit  = 1'b0;
        w_prod   = '0;
        if (o_pop) begin
            if (i_item.start) begin
                n_acc  = '0;
                n_neg  = 1'b0;
                n_ovf  = 1'b0;
                n_seen = 1'b0;
                n_pos  = '0;
                n_eb   = i_item.base;
                n_phase = i_item.bad_base ? PH_IDLE : PH_LEAD;
                if (i_item.bad_base) begin
                    w_emit = 1'b1;
                    n_out  = '{status: ST_BADBASE, end_offset: '0, value: '0};
                end
            end
            if (!(i_item.start && i_item.bad_base)) begin
                unique case (n_phase)
                    PH_IDLE: begin
                    end
                    PH_LEAD: begin
                        if (i_item.is_space) begin
                            w_adv = 1'b1;
                        end else if (i_item.is_sign) begin
                            n_neg   = i_item.is_minus;
                            n_phase = PH_SIGNED;
                            w_adv   = 1'b1;
                        end else begin
                            w_prefix = 1'b1;
                        end
                    end
                    PH_SIGNED: begin
                        w_prefix = 1'b1;
                    end
                    PH_ZERO: begin
                        if (i_item.is_x) begin
                            n_eb    = BASE_HEX;
                            n_phase = PH_DIGITS;
                            w_adv   = 1'b1;
                        end else begin
                            if (n_eb == BASE_AUTO) begin
                                n_eb = BASE_OCT;
                            end
                            // the leading zero counts as a digit
                            n_seen  = 1'b1;
                            n_acc   = '0;
                            n_phase = PH_DIGITS;
                            w_digit = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        w_digit = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                if (w_prefix) begin
                    if (((n_eb == BASE_AUTO) || (n_eb == BASE_HEX)) && i_item.is_zero) begin
                        n_phase = PH_ZERO;
                        w_adv   = 1'b1;
                    end else begin
                        if (n_eb == BASE_AUTO) begin
                            n_eb = BASE_DEC;
                        end
                        w_digit = 1'b1;
                    end
                end
                if (w_digit) begin
                    if (!i_item.dig_ok || (n_eb < BASE_BITS'(2)) || (i_item.dig >= n_eb)) begin
                        w_emit  = 1'b1;
                        n_phase = PH_IDLE;
                        priority if (!n_seen) begin
                            n_out = '{status: ST_NODIG, end_offset: '0, value: '0};
                        end else if (n_ovf) begin
                            n_out = '{status: ST_OVER, end_offset: n_pos, value: '1};
                        end else begin
                            n_out = '{status: ST_OK, end_offset: n_pos,
                                      value: n_neg ? (VALUE_BITS'(0) - n_acc) : n_acc};
                        end
                    end else begin
                        // carry out of the top 64 bits marks overflow
                        w_prod = ({{BASE_BITS{1'b0}}, n_acc} * PROD_W'(n_eb))
                                 + PROD_W'(i_item.dig);
                        if (!n_ovf) begin
                            if (w_prod[PROD_W-1:VALUE_BITS] != '0) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_acc = w_prod[VALUE_BITS-1:0];
                            end
                        end
                        n_seen  = 1'b1;
                        n_phase = PH_DIGITS;
                        w_adv   = 1'b1;
                    end
                end
                if (w_adv && (n_pos != POS_MAX)) begin
                    n_pos = n_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_eb        <= BASE_RESET;
            r_ovf       <= 1'b0;
            r_seen      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_eb    <= n_eb;
            r_ovf   <= n_ovf;
            r_seen  <= n_seen;
            r_pos   <= n_pos;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`include "parse_unsigned_integer_text_unit_macros.svh"

    `PUI_ASSERT_NOW(a_over_all_ones, r_out_valid && (r_out.status == ST_OVER), r_out.value == '1)
    `PUI_ASSERT_NOW(a_nodig_zero, r_out_valid && ((r_out.status == ST_NODIG) || (r_out.status == ST_BADBASE)), (r_out.value == '0) && (r_out.end_offset == '0))
    `PUI_ASSERT_NEXT(a_emit_goes_idle, w_emit, r_phase == PH_IDLE)

endmodule

// ===== rtl/core/parse_unsigned_integer_text_unit.sv =====
// top level of the streaming text-to-unsigned-integer parser
// Usage:
//   s_axis carries one character a beat in tdata[7:0]; tuser[0] marks the first
//   character of a new string. Leading white space, an optional sign and a
//   base prefix (when the base register is 0 or 16) are handled as strtoul does.
//   m_axis carries one result beat per parsed string, at the first character
//   that is not a digit of the base, or at NUL; a bad base ends it at the start.
//   The cfg channel writes the 6-bit base register (reset 10); it is taken at
//   each start character; the user must write it only while idle (not enforced).
// Throughput: one character per cycle while the queue has room, bounded by the
//   combinational 64x6 multiply-add of the accumulator in the back end.
// Path: the ending character accepted on s_axis is first written into the
//   queue, then popped by the back end into the result register that drives
//   m_axis; characters queued ahead of it are parsed first.
// Stall: a four-entry queue sits between classification and parsing and a
//   result register sits at the output, so s_axis keeps accepting while a
//   result waits; when the queue fills, s_axis_tready drops.
// Reset: synchronous, active low; the base returns to 10, the queue empties,
//   the parser goes idle and no result is pending.
module parse_unsigned_integer_text_unit
    import puit_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [BASE_BITS-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CHAR_BITS-1:0] s_axis_tdata,   // char_byte
    input  logic                 s_axis_tuser,   // start_req
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata    // value, end_offset, status, zero pad
);

    logic    w_q_ready;
    logic    w_push;
    t_item   w_in_item;
    logic    w_q_valid;
    logic    w_pop;
    t_item   w_q_item;
    t_result w_result;

    puit_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_char      (s_axis_tdata),
        .i_start     (s_axis_tuser),
        .i_q_ready   (w_q_ready),
        .o_push      (w_push),
        .o_item      (w_in_item)
    );

    puit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    puit_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (w_result)
    );

    assign m_axis_tdata = TDATA_W'(w_result);

endmodule
